[rtl/core/pidaw_pkg.sv]
package pidaw_pkg;

   // configuration register file
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 24;

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   localparam csr_addr_type CSR_GAIN_P         = 3'd0;
   localparam csr_addr_type CSR_GAIN_I         = 3'd1;
   localparam csr_addr_type CSR_GAIN_D         = 3'd2;
   localparam csr_addr_type CSR_DRIVE_FLOOR    = 3'd3;
   localparam csr_addr_type CSR_DRIVE_CEILING  = 3'd4;
   localparam csr_addr_type CSR_WINDUP_LIMIT   = 3'd5;
   localparam csr_addr_type CSR_INITIAL_PERIOD = 3'd6;

   // field widths
   localparam int unsigned GAIN_W    = 24;
   localparam int unsigned GAIN_FRAC = 16;
   localparam int unsigned LIMIT_W   = 23;
   localparam int unsigned PERIOD_W  = 24;
   localparam int unsigned ELAPSED_W = 32;

   // one multiplier bit per cycle, multiplier operand is always GAIN_W wide
   localparam int unsigned MUL_BITS = GAIN_W;

   localparam logic [PERIOD_W-1:0]  US_PER_SEC         = 24'd1000000;
   localparam logic [PERIOD_W-1:0]  FALLBACK_PERIOD_US = 24'd10000;
   localparam logic [ELAPSED_W-1:0] ELAPSED_LIMIT      = 32'd1000000;

   // register reset values
   localparam logic [GAIN_W-1:0]   GAIN_P_RST         = 24'd65536;
   localparam logic [GAIN_W-1:0]   GAIN_I_RST         = 24'd3277;
   localparam logic [GAIN_W-1:0]   GAIN_D_RST         = 24'd13107;
   localparam logic [23:0]         DRIVE_FLOOR_RST    = 24'd0;
   localparam logic [23:0]         DRIVE_CEILING_RST  = 24'd25600;
   localparam logic [LIMIT_W-1:0]  WINDUP_LIMIT_RST   = 23'd12800;
   localparam logic [PERIOD_W-1:0] INITIAL_PERIOD_RST = 24'd10000;

endpackage

[rtl/core/pid_controller_antiwindup.sv]
// PID step with a clamped integrator. Each req_ transfer carries a setpoint, a
// measurement (both signed Q16.8) and the microseconds since the last update;
// each one yields exactly one rsp_ transfer with the drive value, clamped to
// [drive_floor, drive_ceiling] (floor wins if the two cross) and saturated to
// DATA_WIDTH bits. Gains are unsigned Q8.16 and every product is truncated
// toward zero on its magnitude. All arithmetic runs through one shared
// shift-add multiplier (one multiplier bit per cycle) and one restoring
// divider (one quotient bit per cycle). The block takes a new item only
// once it is done with the last one; the derivative is skipped when the
// stored measurement is zero. A finished result waits in the output
// register while the next item is already accepted; it only holds up the
// sequencer if it is still unread when the next result is ready. The first
// item after reset takes its period from initial_period_us; later items take
// the elapsed time when it lies strictly between 0 and 1000000. Write
// configuration only while the block is idle.
module pid_controller_antiwindup #(
   parameter int unsigned DATA_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata, lowest bit up: target, sensed, interval_us, zero fill
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((2*DATA_WIDTH+32+7)/8)*8-1:0]  req_tdata,
   // rsp_tdata, lowest bit up: drive, zero fill
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((DATA_WIDTH+7)/8)*8-1:0]       rsp_tdata,
   input  logic                                  csr_wr_en,
   input  pidaw_pkg::csr_addr_type               csr_index,
   input  logic [pidaw_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned DW     = DATA_WIDTH;
   localparam int unsigned RSP_TW = ((DW + 7) / 8) * 8;
   // dividend / multiplicand register: largest dividend is |x| * 2^24
   localparam int unsigned OW     = DW + 24;
   // product register: largest product is rate * gain_d
   localparam int unsigned AW     = DW + 44;
   // signed accumulator for the three terms
   localparam int unsigned SW     = DW + 30;
   // signed integrator working width, room for the 23-bit limit
   localparam int unsigned IW     = (DW + 7 > 25) ? DW + 7 : 25;
   localparam int unsigned CW     = $clog2(OW);

   localparam int unsigned PW = pidaw_pkg::PERIOD_W;
   localparam int unsigned GW = pidaw_pkg::GAIN_W;

   localparam logic signed [SW-1:0] S_MAX = SW'((64'd1 << (DW - 1)) - 64'd1);
   localparam logic signed [SW-1:0] S_MIN = ~S_MAX;
   localparam logic signed [IW-1:0] I_MAX = IW'((64'd1 << (DW - 1)) - 64'd1);
   localparam logic signed [IW-1:0] I_MIN = ~I_MAX;

   localparam logic [CW-1:0] MUL_LAST = CW'(pidaw_pkg::MUL_BITS - 1);
   localparam logic [CW-1:0] DIV_LAST = CW'(OW - 1);

   // sequencer states
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_PREP     = 4'd1;
   localparam logic [3:0] ST_MUL_INC  = 4'd2;
   localparam logic [3:0] ST_DIV_INC  = 4'd3;
   localparam logic [3:0] ST_INTEG    = 4'd4;
   localparam logic [3:0] ST_LOAD_I   = 4'd5;
   localparam logic [3:0] ST_MUL_I    = 4'd6;
   localparam logic [3:0] ST_ADD_I    = 4'd7;
   localparam logic [3:0] ST_MUL_P    = 4'd8;
   localparam logic [3:0] ST_ADD_P    = 4'd9;
   localparam logic [3:0] ST_MUL_RATE = 4'd10;
   localparam logic [3:0] ST_DIV_RATE = 4'd11;
   localparam logic [3:0] ST_MUL_D    = 4'd12;
   localparam logic [3:0] ST_ADD_D    = 4'd13;
   localparam logic [3:0] ST_CLAMP    = 4'd14;
   localparam logic [3:0] ST_OUT      = 4'd15;

   // control state
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          started_ff, started_in;
   logic [PW-1:0] period_ff, period_in;
   logic signed [DW-1:0] integ_ff, integ_in;
   logic [DW-1:0] last_sensed_ff, last_sensed_in;

   // configuration registers
   logic [GW-1:0]        gain_p_ff, gain_p_in;
   logic [GW-1:0]        gain_i_ff, gain_i_in;
   logic [GW-1:0]        gain_d_ff, gain_d_in;
   logic signed [23:0]   floor_ff, floor_in;
   logic signed [23:0]   ceiling_ff, ceiling_in;
   logic [pidaw_pkg::LIMIT_W-1:0] windup_ff, windup_in;
   logic [PW-1:0]        init_period_ff, init_period_in;

   // datapath payload
   logic [DW-1:0]        rsp_drive_ff, rsp_drive_in;
   logic signed [DW:0]   err_ff, err_in;
   logic signed [DW:0]   dm_ff, dm_in;
   logic [DW-1:0]        err_mag_ff, err_mag_in;
   logic [DW-1:0]        dm_mag_ff, dm_mag_in;
   logic                 dskip_ff, dskip_in;
   logic [PW-1:0]        dt_ff, dt_in;
   logic [OW-1:0]        opa_ff, opa_in;
   logic [GW-1:0]        opb_ff, opb_in;
   logic [AW-1:0]        acc_ff, acc_in;
   logic [GW-1:0]        rem_ff, rem_in;
   logic signed [SW-1:0] sum_ff, sum_in;

   // input unpacking
   logic [DW-1:0]                   req_target;
   logic [DW-1:0]                   req_sensed;
   logic [pidaw_pkg::ELAPSED_W-1:0] req_elapsed;
   logic [PW-1:0]                   period_sel;

   // shared multiplier and divider step
   logic [AW-1:0] acc_step;
   logic [GW-1:0] opb_step;
   logic [GW:0]   div_trial;
   logic [GW:0]   div_diff;
   logic          div_ge;
   logic [GW-1:0] rem_step;
   logic [OW-1:0] opa_div;

   // magnitudes
   logic [DW:0]   err_neg_val;
   logic [DW:0]   dm_neg_val;
   logic [DW-1:0] err_abs;
   logic [DW-1:0] dm_abs;
   logic [DW-1:0] integ_abs;

   // term accumulation
   logic [SW-1:0]        add_term;
   logic                 add_neg;
   logic signed [SW-1:0] sum_acc;

   // integrator update
   logic signed [IW-1:0] int_ext;
   logic [IW-1:0]        int_inc;
   logic signed [IW-1:0] int_sum;
   logic signed [IW-1:0] int_lim;
   logic signed [IW-1:0] int_a;
   logic signed [IW-1:0] int_b;
   logic signed [IW-1:0] int_c;

   // output clamps
   logic signed [SW-1:0] ceil_ext;
   logic signed [SW-1:0] floor_ext;
   logic signed [SW-1:0] clamp_hi;
   logic signed [SW-1:0] clamp_lo;
   logic signed [SW-1:0] out_sat;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TW'(rsp_drive_ff);

   assign req_target  = req_tdata[DW-1:0];
   assign req_sensed  = req_tdata[2*DW-1:DW];
   assign req_elapsed = req_tdata[2*DW+pidaw_pkg::ELAPSED_W-1:2*DW];

   // first item takes the configured period, later ones a plausible elapsed time
   always_comb begin
      if (!started_ff) begin
         period_sel = init_period_ff;
      end else if (req_elapsed != '0 && req_elapsed < pidaw_pkg::ELAPSED_LIMIT) begin
         period_sel = req_elapsed[PW-1:0];
      end else begin
         period_sel = period_ff;
      end
   end

   // multiply: MSB-first shift-add, one multiplier bit per cycle
   assign acc_step = (acc_ff << 1) + (opb_ff[GW-1] ? AW'(opa_ff) : '0);
   assign opb_step = opb_ff << 1;

   // divide: restoring, quotient bits shift into the dividend register
   assign div_trial = {rem_ff, opa_ff[OW-1]};
   assign div_diff  = div_trial - {1'b0, opb_ff};
   assign div_ge    = (div_trial >= {1'b0, opb_ff});
   assign rem_step  = div_ge ? div_diff[GW-1:0] : div_trial[GW-1:0];
   assign opa_div   = {opa_ff[OW-2:0], div_ge};

   assign err_neg_val = ~err_ff + 1'b1;
   assign dm_neg_val  = ~dm_ff + 1'b1;
   assign err_abs     = err_ff[DW] ? err_neg_val[DW-1:0] : err_ff[DW-1:0];
   assign dm_abs      = dm_ff[DW] ? dm_neg_val[DW-1:0] : dm_ff[DW-1:0];
   assign integ_abs   = integ_ff[DW-1] ? (~integ_ff + 1'b1) : integ_ff;

   // add the product (already >> GAIN_FRAC) with its sign; derivative enters negated
   assign add_term = SW'(acc_ff[AW-1:pidaw_pkg::GAIN_FRAC]);
   assign add_neg  = (state_ff == ST_ADD_I) ? integ_ff[DW-1] :
                     (state_ff == ST_ADD_P) ? err_ff[DW] : ~dm_ff[DW];
   assign sum_acc  = sum_ff + (add_term ^ {SW{add_neg}}) + SW'(add_neg);

   // integrator: add signed increment, clamp to +/- limit, then to field range
   assign int_ext = {{(IW-DW){integ_ff[DW-1]}}, integ_ff};
   assign int_inc = IW'(opa_ff[DW+4:0]);
   assign int_sum = int_ext + (int_inc ^ {IW{err_ff[DW]}}) + IW'(err_ff[DW]);
   assign int_lim = IW'(windup_ff);
   assign int_a   = (int_sum > int_lim) ? int_lim : int_sum;
   assign int_b   = (int_a < -int_lim) ? -int_lim : int_a;
   assign int_c   = (int_b > I_MAX) ? I_MAX : ((int_b < I_MIN) ? I_MIN : int_b);

   // output: ceiling first, floor second, then field saturation
   assign ceil_ext  = {{(SW-24){ceiling_ff[23]}}, ceiling_ff};
   assign floor_ext = {{(SW-24){floor_ff[23]}}, floor_ff};
   assign clamp_hi  = (sum_ff > ceil_ext) ? ceil_ext : sum_ff;
   assign clamp_lo  = (clamp_hi < floor_ext) ? floor_ext : clamp_hi;
   assign out_sat   = (sum_ff > S_MAX) ? S_MAX : ((sum_ff < S_MIN) ? S_MIN : sum_ff);

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      started_in     = started_ff;
      period_in      = period_ff;
      integ_in       = integ_ff;
      last_sensed_in = last_sensed_ff;
      gain_p_in      = gain_p_ff;
      gain_i_in      = gain_i_ff;
      gain_d_in      = gain_d_ff;
      floor_in       = floor_ff;
      ceiling_in     = ceiling_ff;
      windup_in      = windup_ff;
      init_period_in = init_period_ff;
      rsp_drive_in   = rsp_drive_ff;
      err_in         = err_ff;
      dm_in          = dm_ff;
      err_mag_in     = err_mag_ff;
      dm_mag_in      = dm_mag_ff;
      dskip_in       = dskip_ff;
      dt_in          = dt_ff;
      opa_in         = opa_ff;
      opb_in         = opb_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      sum_in         = sum_ff;

      // register writes; unknown indexes drop
      if (csr_wr_en) begin
         case (csr_index)
            pidaw_pkg::CSR_GAIN_P:         gain_p_in      = csr_wdata[GW-1:0];
            pidaw_pkg::CSR_GAIN_I:         gain_i_in      = csr_wdata[GW-1:0];
            pidaw_pkg::CSR_GAIN_D:         gain_d_in      = csr_wdata[GW-1:0];
            pidaw_pkg::CSR_DRIVE_FLOOR:    floor_in       = csr_wdata[23:0];
            pidaw_pkg::CSR_DRIVE_CEILING:  ceiling_in     = csr_wdata[23:0];
            pidaw_pkg::CSR_WINDUP_LIMIT:   windup_in      = csr_wdata[pidaw_pkg::LIMIT_W-1:0];
            pidaw_pkg::CSR_INITIAL_PERIOD: init_period_in = csr_wdata[PW-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               err_in         = {req_target[DW-1], req_target} - {req_sensed[DW-1], req_sensed};
               dm_in          = {req_sensed[DW-1], req_sensed}
                                - {last_sensed_ff[DW-1], last_sensed_ff};
               dskip_in       = (last_sensed_ff == '0);
               last_sensed_in = req_sensed;
               started_in     = 1'b1;
               period_in      = period_sel;
               dt_in          = (period_sel == '0) ? pidaw_pkg::FALLBACK_PERIOD_US : period_sel;
               sum_in         = '0;
               state_in       = ST_PREP;
            end
         end
         ST_PREP: begin
            err_mag_in = err_abs;
            dm_mag_in  = dm_abs;
            opa_in     = OW'(err_abs);
            opb_in     = dt_ff;
            acc_in     = '0;
            cnt_in     = '0;
            state_in   = ST_MUL_INC;
         end
         ST_MUL_INC, ST_MUL_I, ST_MUL_P, ST_MUL_RATE, ST_MUL_D: begin
            acc_in = acc_step;
            opb_in = opb_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in = '0;
               case (state_ff)
                  ST_MUL_INC: begin
                     // |err| * dt / 1e6
                     opa_in   = acc_step[OW-1:0];
                     opb_in   = pidaw_pkg::US_PER_SEC;
                     rem_in   = '0;
                     state_in = ST_DIV_INC;
                  end
                  ST_MUL_RATE: begin
                     // |dmeas| * 1e6 / dt
                     opa_in   = acc_step[OW-1:0];
                     opb_in   = dt_ff;
                     rem_in   = '0;
                     state_in = ST_DIV_RATE;
                  end
                  ST_MUL_I: state_in = ST_ADD_I;
                  ST_MUL_P: state_in = ST_ADD_P;
                  default:  state_in = ST_ADD_D;
               endcase
            end
         end
         ST_DIV_INC, ST_DIV_RATE: begin
            opa_in = opa_div;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in = '0;
               if (state_ff == ST_DIV_INC) begin
                  state_in = ST_INTEG;
               end else begin
                  opb_in   = gain_d_ff;
                  acc_in   = '0;
                  state_in = ST_MUL_D;
               end
            end
         end
         ST_INTEG: begin
            integ_in = int_c[DW-1:0];
            state_in = ST_LOAD_I;
         end
         ST_LOAD_I: begin
            opa_in   = OW'(integ_abs);
            opb_in   = gain_i_ff;
            acc_in   = '0;
            cnt_in   = '0;
            state_in = ST_MUL_I;
         end
         ST_ADD_I: begin
            sum_in   = sum_acc;
            opa_in   = OW'(err_mag_ff);
            opb_in   = gain_p_ff;
            acc_in   = '0;
            cnt_in   = '0;
            state_in = ST_MUL_P;
         end
         ST_ADD_P: begin
            sum_in = sum_acc;
            if (dskip_ff) begin
               state_in = ST_CLAMP;
            end else begin
               opa_in   = OW'(dm_mag_ff);
               opb_in   = pidaw_pkg::US_PER_SEC;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_MUL_RATE;
            end
         end
         ST_ADD_D: begin
            sum_in   = sum_acc;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            sum_in   = clamp_lo;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_drive_in = out_sat[DW-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         started_ff     <= 1'b0;
         period_ff      <= pidaw_pkg::INITIAL_PERIOD_RST;
         integ_ff       <= '0;
         last_sensed_ff <= '0;
         gain_p_ff      <= pidaw_pkg::GAIN_P_RST;
         gain_i_ff      <= pidaw_pkg::GAIN_I_RST;
         gain_d_ff      <= pidaw_pkg::GAIN_D_RST;
         floor_ff       <= pidaw_pkg::DRIVE_FLOOR_RST;
         ceiling_ff     <= pidaw_pkg::DRIVE_CEILING_RST;
         windup_ff      <= pidaw_pkg::WINDUP_LIMIT_RST;
         init_period_ff <= pidaw_pkg::INITIAL_PERIOD_RST;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         started_ff     <= started_in;
         period_ff      <= period_in;
         integ_ff       <= integ_in;
         last_sensed_ff <= last_sensed_in;
         gain_p_ff      <= gain_p_in;
         gain_i_ff      <= gain_i_in;
         gain_d_ff      <= gain_d_in;
         floor_ff       <= floor_in;
         ceiling_ff     <= ceiling_in;
         windup_ff      <= windup_in;
         init_period_ff <= init_period_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_drive_ff <= rsp_drive_in;
      err_ff       <= err_in;
      dm_ff        <= dm_in;
      err_mag_ff   <= err_mag_in;
      dm_mag_ff    <= dm_mag_in;
      dskip_ff     <= dskip_in;
      dt_ff        <= dt_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      sum_ff       <= sum_in;
   end

`ifndef SYNTHESIS
   // a result only appears out of the final state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_OUT))
      else $error("result appeared outside the output state");

   // partial remainder always stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_INC || state_ff == ST_DIV_RATE) |-> (rem_ff < opb_ff))
      else $error("divider remainder out of range");

   // an accepted item always starts the preparation step
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_PREP))
      else $error("accepted item did not start the sequence");

   // derivative path only runs with a nonzero stored measurement
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_RATE || state_ff == ST_DIV_RATE || state_ff == ST_MUL_D)
      |-> !dskip_ff)
      else $error("derivative computed while it should be skipped");
`endif

endmodule
